FILE: hdl/swc_pkg.sv
// Shared types, constants and helpers for the sync word correlator.
// No dependencies.
package swc_pkg;

   localparam int WinW           = 64;
   localparam int ShortW         = 32;
   localparam int SyncRegs       = 4;
   localparam int CntW           = 7;
   localparam int IdxW           = 2;
   localparam int CsrIdxW        = 3;
   localparam int WordsW         = 3;
   localparam int ByteW          = 8;
   localparam int DecBit         = 7;
   localparam int GroupW         = 8;
   localparam int Groups         = WinW / GroupW;
   localparam int GrpCntW        = 4;
   localparam int NumPatternsDef = 4;
   localparam int PosWidthDef    = 16;

   localparam logic [CsrIdxW-1:0] RegSync0      = 3'd0;
   localparam logic [CsrIdxW-1:0] RegSync1      = 3'd1;
   localparam logic [CsrIdxW-1:0] RegSync2      = 3'd2;
   localparam logic [CsrIdxW-1:0] RegSync3      = 3'd3;
   localparam logic [CsrIdxW-1:0] RegWordsInUse = 3'd4;
   localparam logic [CsrIdxW-1:0] RegLongWords  = 3'd5;

   typedef struct packed {
      logic            valid;
      logic            score;
      logic            last;
      logic [WinW-1:0] window;
   } token_type;

   typedef struct packed {
      logic [CntW-1:0] cnt;
      logic [IdxW-1:0] idx;
   } best_type;

   function automatic logic [GrpCntW-1:0] pop8(input logic [GroupW-1:0] v);
      logic [GrpCntW-1:0] c;
      c = '0;
      for (int i = 0; i < GroupW; i++) begin
         c = c + GrpCntW'(v[i]);
      end
      return c;
   endfunction

endpackage

FILE: hdl/sync_word_correlator.sv
// Sync word correlator, top level: registers, bit window and cell chain.
// Throughput one request per cycle while req_ready is high; a frame's last request sends
// one result per pattern in use, one per cycle while rsp_ready is high. The first result
// passes the input stage, stage A of each cell, stages B and C of the last cell and the
// result buffer. Synchronous reset clears window, position, peaks, chosen word, pipeline
// and registers (patterns 0, one pattern in use, short mode). Depends on swc_pkg.
module sync_word_correlator #(
   parameter int NUM_PATTERNS = swc_pkg::NumPatternsDef,
   parameter int POS_WIDTH    = swc_pkg::PosWidthDef
) (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              req_valid,
   output logic                              req_ready,
   input  logic [swc_pkg::ByteW-1:0]         req_data_byte,
   input  logic                              req_last_byte,
   output logic                              rsp_valid,
   input  logic                              rsp_ready,
   output logic [swc_pkg::IdxW-1:0]          rsp_word_index,
   output logic [swc_pkg::CntW-1:0]          rsp_peak_matches,
   output logic [POS_WIDTH-1:0]              rsp_peak_position,
   output logic [swc_pkg::IdxW-1:0]          rsp_best_word,
   output logic                              rsp_last,
   input  logic                              csr_valid,
   output logic                              csr_ready,
   input  logic [swc_pkg::CsrIdxW-1:0]       csr_index,
   input  logic [swc_pkg::WinW-1:0]          csr_data
);

   localparam int NCell = (NUM_PATTERNS < swc_pkg::SyncRegs) ? NUM_PATTERNS
                                                            : swc_pkg::SyncRegs;

   logic [swc_pkg::WinW-1:0]     sync_ff [swc_pkg::SyncRegs];
   logic [swc_pkg::WordsW-1:0]   words_ff;
   logic                         long_ff;
   logic [swc_pkg::WordsW-1:0]   n_act_w;

   logic [swc_pkg::WinW-1:0]     win_ff, win_next;
   logic [POS_WIDTH-1:0]         pos_ff, wlen_m1;
   swc_pkg::token_type           tok0_ff;
   logic [POS_WIDTH-1:0]         start0_ff;
   logic                         adv, accept;

   swc_pkg::token_type                                tok_w   [NCell+1];
   logic [POS_WIDTH-1:0]                              start_w [NCell+1];
   swc_pkg::best_type                                 best_w  [NCell+1];
   logic [swc_pkg::SyncRegs-1:0][swc_pkg::CntW-1:0]   rcnt_w  [NCell+1];
   logic [swc_pkg::SyncRegs-1:0][POS_WIDTH-1:0]       rpos_w  [NCell+1];
   logic                                              done_w  [NCell];

   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < swc_pkg::SyncRegs; i++) begin
            sync_ff[i] <= '0;
         end
         words_ff <= swc_pkg::WordsW'(1);
         long_ff  <= 1'b0;
      end else if (csr_valid) begin
         case (csr_index)
            swc_pkg::RegSync0:      sync_ff[0] <= csr_data;
            swc_pkg::RegSync1:      sync_ff[1] <= csr_data;
            swc_pkg::RegSync2:      sync_ff[2] <= csr_data;
            swc_pkg::RegSync3:      sync_ff[3] <= csr_data;
            swc_pkg::RegWordsInUse: words_ff   <= csr_data[swc_pkg::WordsW-1:0];
            swc_pkg::RegLongWords:  long_ff    <= csr_data[0];
            default: ;
         endcase
      end
   end

   always_comb begin
      if (words_ff == '0) begin
         n_act_w = swc_pkg::WordsW'(1);
      end else if (words_ff > swc_pkg::WordsW'(NCell)) begin
         n_act_w = swc_pkg::WordsW'(NCell);
      end else begin
         n_act_w = words_ff;
      end
   end

   // input stage: bit window and frame position
   always_comb begin
      accept   = req_valid && adv;
      win_next = {win_ff[swc_pkg::WinW-2:0], req_data_byte[swc_pkg::DecBit]};
      wlen_m1  = long_ff ? POS_WIDTH'(swc_pkg::WinW - 1) : POS_WIDTH'(swc_pkg::ShortW - 1);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         win_ff        <= '0;
         pos_ff        <= '0;
         tok0_ff.valid <= 1'b0;
      end else if (adv) begin
         tok0_ff.valid  <= accept;
         tok0_ff.score  <= !req_last_byte && (pos_ff >= wlen_m1);
         tok0_ff.last   <= req_last_byte;
         tok0_ff.window <= win_next;
         start0_ff      <= pos_ff - wlen_m1;
         if (accept) begin
            if (req_last_byte) begin
               win_ff <= '0;
               pos_ff <= '0;
            end else begin
               win_ff <= win_next;
               if (pos_ff != {POS_WIDTH{1'b1}}) begin
                  pos_ff <= pos_ff + POS_WIDTH'(1);
               end
            end
         end
      end
   end

   assign req_ready  = adv;
   assign tok_w[0]   = tok0_ff;
   assign start_w[0] = start0_ff;
   assign best_w[0]  = '0;
   assign rcnt_w[0]  = '0;
   assign rpos_w[0]  = '0;

   for (genvar i = 0; i < NCell; i++) begin : g_cell
      swc_cell #(
         .CELL_INDEX (i),
         .POS_WIDTH  (POS_WIDTH)
      ) u_cell (
         .clock      (clock),
         .reset      (reset),
         .adv        (adv),
         .active     (swc_pkg::WordsW'(i) < n_act_w),
         .long_words (long_ff),
         .sync_word  (sync_ff[i]),
         .tok_i      (tok_w[i]),
         .start_i    (start_w[i]),
         .best_i     (best_w[i]),
         .res_cnt_i  (rcnt_w[i]),
         .res_pos_i  (rpos_w[i]),
         .tok_o      (tok_w[i+1]),
         .start_o    (start_w[i+1]),
         .best_o     (best_w[i+1]),
         .res_cnt_o  (rcnt_w[i+1]),
         .res_pos_o  (rpos_w[i+1]),
         .done_o     (done_w[i])
      );
   end

   swc_out #(
      .POS_WIDTH (POS_WIDTH)
   ) u_out (
      .clock             (clock),
      .reset             (reset),
      .end_valid         (done_w[NCell-1]),
      .res_cnt           (rcnt_w[NCell]),
      .res_pos           (rpos_w[NCell]),
      .best              (best_w[NCell]),
      .n_act             (n_act_w),
      .rsp_ready         (rsp_ready),
      .adv               (adv),
      .rsp_valid         (rsp_valid),
      .rsp_word_index    (rsp_word_index),
      .rsp_peak_matches  (rsp_peak_matches),
      .rsp_peak_position (rsp_peak_position),
      .rsp_best_word     (rsp_best_word),
      .rsp_last          (rsp_last)
   );

endmodule

FILE: hdl/swc_cell.sv
// One correlator cell: match count and peak tracking for one sync pattern.
// Passes the window token and the end-of-frame results to the next cell.
// Depends on swc_pkg.
module swc_cell #(
   parameter int CELL_INDEX = 0,
   parameter int POS_WIDTH  = swc_pkg::PosWidthDef
) (
   input  logic                                                  clock,
   input  logic                                                  reset,
   input  logic                                                  adv,
   input  logic                                                  active,
   input  logic                                                  long_words,
   input  logic [swc_pkg::WinW-1:0]                              sync_word,
   input  swc_pkg::token_type                                    tok_i,
   input  logic [POS_WIDTH-1:0]                                  start_i,
   input  swc_pkg::best_type                                     best_i,
   input  logic [swc_pkg::SyncRegs-1:0][swc_pkg::CntW-1:0]       res_cnt_i,
   input  logic [swc_pkg::SyncRegs-1:0][POS_WIDTH-1:0]           res_pos_i,
   output swc_pkg::token_type                                    tok_o,
   output logic [POS_WIDTH-1:0]                                  start_o,
   output swc_pkg::best_type                                     best_o,
   output logic [swc_pkg::SyncRegs-1:0][swc_pkg::CntW-1:0]       res_cnt_o,
   output logic [swc_pkg::SyncRegs-1:0][POS_WIDTH-1:0]           res_pos_o,
   output logic                                                  done_o
);

   swc_pkg::token_type                                 tok_a_ff, tok_b_ff;
   logic [POS_WIDTH-1:0]                               start_a_ff, start_b_ff;
   logic [swc_pkg::GrpCntW-1:0]                        grp_ff [swc_pkg::Groups];
   logic [swc_pkg::GrpCntW-1:0]                        grp_in [swc_pkg::Groups];
   logic [swc_pkg::CntW-1:0]                           cnt_ff, cnt_in;
   logic [swc_pkg::CntW-1:0]                           peak_cnt_ff, peak_cnt_in;
   logic [POS_WIDTH-1:0]                               peak_pos_ff, peak_pos_in;
   swc_pkg::best_type                                  best_ff, best_in;
   logic [swc_pkg::SyncRegs-1:0][swc_pkg::CntW-1:0]    res_cnt_ff, res_cnt_in;
   logic [swc_pkg::SyncRegs-1:0][POS_WIDTH-1:0]        res_pos_ff, res_pos_in;
   logic                                               done_ff, done_in;
   logic [swc_pkg::WinW-1:0]                           mask_w, match_w;

   // stage A: bitwise match, counted per byte group
   always_comb begin
      mask_w  = long_words ? {swc_pkg::WinW{1'b1}}
                           : swc_pkg::WinW'({swc_pkg::ShortW{1'b1}});
      match_w = ~(tok_i.window ^ sync_word) & mask_w;
      for (int g = 0; g < swc_pkg::Groups; g++) begin
         grp_in[g] = swc_pkg::pop8(match_w[g*swc_pkg::GroupW +: swc_pkg::GroupW]);
      end
   end

   // stage B: total count
   always_comb begin
      cnt_in = '0;
      for (int g = 0; g < swc_pkg::Groups; g++) begin
         cnt_in = cnt_in + swc_pkg::CntW'(grp_ff[g]);
      end
   end

   // stage C: peak update, or end of frame hand-off
   always_comb begin
      peak_cnt_in = peak_cnt_ff;
      peak_pos_in = peak_pos_ff;
      best_in     = best_i;
      res_cnt_in  = res_cnt_i;
      res_pos_in  = res_pos_i;
      done_in     = tok_b_ff.valid && tok_b_ff.last;
      if (tok_b_ff.valid) begin
         if (tok_b_ff.last) begin
            res_cnt_in[CELL_INDEX] = peak_cnt_ff;
            res_pos_in[CELL_INDEX] = peak_pos_ff;
            if (active && (peak_cnt_ff > best_i.cnt)) begin
               best_in.cnt = peak_cnt_ff;
               best_in.idx = swc_pkg::IdxW'(CELL_INDEX);
            end
            peak_cnt_in = '0;
            peak_pos_in = '0;
         end else if (active && tok_b_ff.score && (cnt_ff > peak_cnt_ff)) begin
            peak_cnt_in = cnt_ff;
            peak_pos_in = start_b_ff;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         tok_a_ff.valid <= 1'b0;
         tok_b_ff.valid <= 1'b0;
         done_ff        <= 1'b0;
         peak_cnt_ff    <= '0;
         peak_pos_ff    <= '0;
      end else if (adv) begin
         tok_a_ff    <= tok_i;
         start_a_ff  <= start_i;
         grp_ff      <= grp_in;
         tok_b_ff    <= tok_a_ff;
         start_b_ff  <= start_a_ff;
         cnt_ff      <= cnt_in;
         peak_cnt_ff <= peak_cnt_in;
         peak_pos_ff <= peak_pos_in;
         best_ff     <= best_in;
         res_cnt_ff  <= res_cnt_in;
         res_pos_ff  <= res_pos_in;
         done_ff     <= done_in;
      end
   end

   assign tok_o     = tok_a_ff;
   assign start_o   = start_a_ff;
   assign best_o    = best_ff;
   assign res_cnt_o = res_cnt_ff;
   assign res_pos_o = res_pos_ff;
   assign done_o    = done_ff;

endmodule

FILE: hdl/swc_out.sv
// Result buffer: holds one frame's results and sends one per cycle while rsp_ready is high.
// Stalls the cell chain while a new frame's results cannot be taken.
// Depends on swc_pkg.
module swc_out #(
   parameter int POS_WIDTH = swc_pkg::PosWidthDef
) (
   input  logic                                              clock,
   input  logic                                              reset,
   input  logic                                              end_valid,
   input  logic [swc_pkg::SyncRegs-1:0][swc_pkg::CntW-1:0]   res_cnt,
   input  logic [swc_pkg::SyncRegs-1:0][POS_WIDTH-1:0]       res_pos,
   input  swc_pkg::best_type                                 best,
   input  logic [swc_pkg::WordsW-1:0]                        n_act,
   input  logic                                              rsp_ready,
   output logic                                              adv,
   output logic                                              rsp_valid,
   output logic [swc_pkg::IdxW-1:0]                          rsp_word_index,
   output logic [swc_pkg::CntW-1:0]                          rsp_peak_matches,
   output logic [POS_WIDTH-1:0]                              rsp_peak_position,
   output logic [swc_pkg::IdxW-1:0]                          rsp_best_word,
   output logic                                              rsp_last
);

   logic                                              busy_ff;
   logic [swc_pkg::IdxW-1:0]                          idx_ff;
   logic [swc_pkg::IdxW-1:0]                          chosen_ff;
   logic [swc_pkg::SyncRegs-1:0][swc_pkg::CntW-1:0]   buf_cnt_ff;
   logic [swc_pkg::SyncRegs-1:0][POS_WIDTH-1:0]       buf_pos_ff;
   logic                                              last_w, free_w, load_w;
   logic [swc_pkg::IdxW-1:0]                          pick_w;

   always_comb begin
      last_w = ({1'b0, idx_ff} == (n_act - swc_pkg::WordsW'(1)));
      free_w = !busy_ff || (rsp_ready && last_w);
      load_w = end_valid && free_w;
      adv    = !end_valid || free_w;
      pick_w = (best.cnt == '0) ? chosen_ff : best.idx;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff   <= 1'b0;
         idx_ff    <= '0;
         chosen_ff <= '0;
      end else begin
         if (load_w) begin
            busy_ff    <= 1'b1;
            idx_ff     <= '0;
            chosen_ff  <= pick_w;
            buf_cnt_ff <= res_cnt;
            buf_pos_ff <= res_pos;
         end else if (busy_ff && rsp_ready) begin
            if (last_w) begin
               busy_ff <= 1'b0;
            end else begin
               idx_ff <= idx_ff + swc_pkg::IdxW'(1);
            end
         end
      end
   end

   assign rsp_valid         = busy_ff;
   assign rsp_word_index    = idx_ff;
   assign rsp_peak_matches  = buf_cnt_ff[idx_ff];
   assign rsp_peak_position = buf_pos_ff[idx_ff];
   assign rsp_best_word     = chosen_ff;
   assign rsp_last          = last_w;

endmodule
